[rtl/core/crc32_signature_dedup_set_defines.svh]
// Assertion macros for the signature dedup set.
`ifndef CRC32_SIGNATURE_DEDUP_SET_DEFINES_SVH
`define CRC32_SIGNATURE_DEDUP_SET_DEFINES_SVH

`ifndef SYNTHESIS

`define CRCDD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("crcdd check failed");

`define CRCDD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("crcdd check failed");

`else

`define CRCDD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define CRCDD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/crcdd_pkg.sv]
package crcdd_pkg;

    localparam int unsigned DATA_W     = 8;
    localparam int unsigned CRC_W      = 32;
    localparam int unsigned TABLE_SIZE = 128;
    localparam int unsigned IDX_W      = (TABLE_SIZE > 2) ? $clog2(TABLE_SIZE) : 1;
    localparam int unsigned BIT_W      = $clog2(DATA_W);

    localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [IDX_W-1:0] FULL_COUNT = IDX_W'(TABLE_SIZE - 1);
    localparam logic [BIT_W-1:0] LAST_BIT   = BIT_W'(DATA_W - 1);

endpackage

[rtl/core/crcdd_if.sv]
interface crcdd_byte_if import crcdd_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface crcdd_result_if import crcdd_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [CRC_W-1:0] signature;
    logic             is_new;
    logic             table_full;

    modport source (output valid, signature, is_new, table_full, input ready);
    modport sink   (input valid, signature, is_new, table_full, output ready);
endinterface

interface crcdd_cfg_if import crcdd_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [CRC_W-1:0] crc_seed;

    modport source (output valid, crc_seed, input ready);
    modport sink   (input valid, crc_seed, output ready);
endinterface

[rtl/core/crc32_signature_dedup_set.sv]
// Folds each name byte into a reflected CRC-32 with one shift-and-xor unit, one bit per
// cycle, so a byte must be fully folded before the next byte can be taken.
// On the final byte the signature is compared against the stored signatures one entry at
// a time through the signature memory's single registered read port, with a read state
// and then a compare state per entry; the search stops on a hit and is skipped for a zero
// signature or an empty table. The result sits in an output register, so the next name
// can start while a result waits. The seed register may be written between words only.
`include "crc32_signature_dedup_set_defines.svh"

module crc32_signature_dedup_set import crcdd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    crcdd_cfg_if.sink     i_cfg,
    crcdd_byte_if.sink    i_byte,
    crcdd_result_if.source o_result
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CRC  = 6'b000010,
        S_LOOK = 6'b000100,
        S_READ = 6'b001000,
        S_CMP  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [CRC_W-1:0] r_seed, n_seed;
    logic [CRC_W-1:0] r_crc, n_crc;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             r_last, n_last;
    logic [CRC_W-1:0] r_sig, n_sig;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_found, n_found;
    logic [IDX_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;
    logic [CRC_W-1:0] r_out_sig, n_out_sig;
    logic             r_out_new, n_out_new;
    logic             r_out_full, n_out_full;

    logic [CRC_W-1:0] r_mem [TABLE_SIZE];
    logic [CRC_W-1:0] r_rd_data;

    logic [CRC_W-1:0] crc_step;
    logic             byte_fire;
    logic             out_free;
    logic             out_load;
    logic             mem_we;

    assign i_cfg.ready  = 1'b1;
    assign i_byte.ready = (r_state == S_IDLE);
    assign byte_fire    = i_byte.valid && i_byte.ready;
    assign out_free     = !r_out_valid || o_result.ready;

    assign o_result.valid      = r_out_valid;
    assign o_result.signature  = r_out_sig;
    assign o_result.is_new     = r_out_new;
    assign o_result.table_full = r_out_full;

    assign crc_step = {1'b0, r_crc[CRC_W-1:1]} ^ (r_crc[0] ? CRC_POLY : '0);

    always_comb begin
        n_state     = r_state;
        n_seed      = r_seed;
        n_crc       = r_crc;
        n_bit       = r_bit;
        n_last      = r_last;
        n_sig       = r_sig;
        n_idx       = r_idx;
        n_found     = r_found;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out_sig   = r_out_sig;
        n_out_new   = r_out_new;
        n_out_full  = r_out_full;
        out_load    = 1'b0;
        mem_we      = 1'b0;

        if (o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (byte_fire) begin
                    n_crc   = r_crc ^ {{(CRC_W-DATA_W){1'b0}}, i_byte.data_byte};
                    n_last  = i_byte.last_byte;
                    n_bit   = '0;
                    n_state = S_CRC;
                end
            end
            S_CRC: begin
                n_crc = crc_step;
                n_bit = r_bit + 1'b1;
                if (r_bit == LAST_BIT) begin
                    if (r_last) begin
                        n_sig   = ~crc_step;
                        n_crc   = ~r_seed;
                        n_state = S_LOOK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LOOK: begin
                n_found = 1'b0;
                n_idx   = '0;
                if ((r_sig == '0) || (r_count == '0)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_rd_data == r_sig) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else if (r_idx == r_count - 1'b1) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_sig   = r_sig;
                    n_out_new   = !r_found;
                    n_out_full  = !r_found && (r_count == FULL_COUNT);
                    mem_we      = !r_found && (r_count != FULL_COUNT) && (r_sig != '0);
                    if (mem_we) begin
                        n_count = r_count + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // reload drops any partial name
        if (i_cfg.valid && i_cfg.ready) begin
            n_seed = i_cfg.crc_seed;
            n_crc  = ~i_cfg.crc_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= '0;
            r_crc       <= '1;
            r_bit       <= '0;
            r_last      <= 1'b0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seed      <= n_seed;
            r_crc       <= n_crc;
            r_bit       <= n_bit;
            r_last      <= n_last;
            r_idx       <= n_idx;
            r_found     <= n_found;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sig      <= n_sig;
        r_out_sig  <= n_out_sig;
        r_out_new  <= n_out_new;
        r_out_full <= n_out_full;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count] <= r_sig;
        end
        r_rd_data <= r_mem[r_idx];
    end

    `CRCDD_ASSERT_NXT(a_byte_starts_fold, i_clk, i_rst_n, byte_fire, r_state == S_CRC)
    `CRCDD_ASSERT_IMP(a_cmp_in_range, i_clk, i_rst_n, r_state == S_CMP, r_idx < r_count)
    `CRCDD_ASSERT_NXT(a_store_bumps_count, i_clk, i_rst_n, mem_we, r_count == $past(r_count) + 1'b1)
    `CRCDD_ASSERT_NXT(a_load_sets_valid, i_clk, i_rst_n, out_load, o_result.valid && (r_state == S_IDLE))

endmodule
